FILE: hw/rtl/cpg_pkg.sv
// Shared types and constants of the close point grouping block
`timescale 1ns / 1ps

package cpg_pkg;

  localparam int COORD_W    = 24;
  localparam int PROD_W     = 2 * COORD_W;
  localparam int SUM_W      = 50;
  localparam int DIMS_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 50;
  localparam int GRP_W      = 6;
  localparam int GRP_NUM_W  = 5;
  localparam int STATUS_W   = 2;

  localparam int DEF_MAX_NODES = 64;
  localparam int DEF_MAX_DIMS  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_DIMS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOL  = 1'd1;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_CONFLICT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

  localparam logic [DIMS_W-1:0] DIMS_RESET = 2'd3;

  typedef struct packed {
    logic clr;
    logic mul;
    logic acc;
  } dist_ctl_t;

endpackage

FILE: hw/rtl/cpg_ram.sv
// Generic single write port, single read port RAM with registered read
`timescale 1ns / 1ps

module cpg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/cpg_dist_unit.sv
// Shared subtract, square and accumulate unit for squared distances
`timescale 1ns / 1ps

module cpg_dist_unit
  import cpg_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dist_ctl_t                 ctl_i,
  input  logic signed [COORD_W-1:0] a_i,
  input  logic signed [COORD_W-1:0] b_i,
  input  logic        [SUM_W-1:0]   tol_i,
  output logic                      close_o
);

  logic signed [COORD_W:0] diff;
  logic        [COORD_W:0] neg;
  logic [COORD_W-1:0]      mag;
  logic [PROD_W-1:0]       prod_d, prod_q;
  logic [SUM_W-1:0]        sum_d, sum_q;

  always_comb begin
    diff   = {a_i[COORD_W-1], a_i} - {b_i[COORD_W-1], b_i};
    neg    = -diff;
    mag    = diff[COORD_W] ? neg[COORD_W-1:0] : diff[COORD_W-1:0];
    prod_d = mag * mag;
    sum_d  = sum_q;
    if (ctl_i.clr) begin
      sum_d = '0;
    end else if (ctl_i.acc) begin
      sum_d = sum_q + SUM_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul) begin
      prod_q <= prod_d;
    end
  end

  assign close_o = sum_q < tol_i;

endmodule

FILE: hw/rtl/close_point_grouping_core.sv
// Top level of the close point grouping block: sequencer, stores and output register
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid_i / in_ready_o) takes one point per transaction.
//   Points are written to the point store at one per cycle while the block
//   is idle. A transaction with last_point_i set starts grouping; in_ready_o
//   stays low until every result of the set has been handed to the output
//   register. Points beyond MAX_NODES are dropped and flag overflow.
//   Grouping visits every pair (i, j), i < j, of ungrouped outer points with
//   one shared subtract-square-accumulate unit: the partner is read, each
//   dimension is squared and then accumulated in turn, and the sum is
//   compared with the tolerance. Grouped outer points are skipped.
//   Results then leave one at a time through a registered output
//   (out_valid_o / out_ready_i); each is read from the group store and then
//   loaded, and a stalled receiver holds the sequencer.
//   After the final result is loaded the set is cleared and in_ready_o rises
//   again while that result may still wait to be taken.
//   Reset clears the set and the registers (dims 3, tolerance 0); the point
//   store is not cleared, only loaded entries are ever read.
//   Configuration writes (cfg_we_i) take effect at once; the user must make
//   them only while the block is idle, which the block itself does not enforce.

module close_point_grouping_core
  import cpg_pkg::*;
#(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int MAX_DIMS  = DEF_MAX_DIMS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic        [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic        [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_W-1:0]    coord_x_i,
  input  logic signed [COORD_W-1:0]    coord_y_i,
  input  logic signed [COORD_W-1:0]    coord_z_i,
  input  logic                         last_point_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [GRP_W-1:0]      point_group_o,
  output logic        [GRP_W-1:0]      groups_found_o,
  output logic        [STATUS_W-1:0]   status_o,
  output logic                         last_result_o
);

  localparam int IW = $clog2(MAX_NODES);
  localparam int NW = $clog2(MAX_NODES + 1);
  localparam int KW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int PW = MAX_DIMS * COORD_W;
  localparam logic [NW-1:0]     NodesMax = NW'(MAX_NODES);
  localparam logic [DIMS_W-1:0] DimsMax  = DIMS_W'(MAX_DIMS);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_OUTER   = 4'd1;
  localparam logic [3:0] S_LATCH_I = 4'd2;
  localparam logic [3:0] S_INNER   = 4'd3;
  localparam logic [3:0] S_MUL     = 4'd4;
  localparam logic [3:0] S_ACC     = 4'd5;
  localparam logic [3:0] S_CMP     = 4'd6;
  localparam logic [3:0] S_OUT_RD  = 4'd7;
  localparam logic [3:0] S_OUT_LD  = 4'd8;

  logic [3:0]           state_q, state_d;
  logic [NW-1:0]        pts_q, pts_d, i_q, i_d, j_q, j_d;
  logic [KW-1:0]        k_q, k_d;
  logic [GRP_W-1:0]     grp_cnt_q, grp_cnt_d;
  logic                 ovf_q, ovf_d, cflt_q, cflt_d, part_q, part_d;
  logic [MAX_NODES-1:0] grp_vld_q, grp_vld_d;
  logic [DIMS_W-1:0]    dims_q;
  logic [SUM_W-1:0]     tol_q;

  logic [MAX_DIMS-1:0][COORD_W-1:0] pi_q, pi_d;
  logic [MAX_DIMS-1:0][COORD_W-1:0] pw_data, pr_data;
  logic                              pi_ld;

  logic                 out_valid_q, out_valid_d, out_ld;
  logic [GRP_W-1:0]     out_grp_d, out_grp_q;
  logic [GRP_W-1:0]     out_cnt_q;
  logic [STATUS_W-1:0]  out_stat_d, out_stat_q;
  logic                 out_last_d, out_last_q;

  logic                 p_we, p_re, g_we, g_re;
  logic [IW-1:0]        p_raddr, g_waddr;
  logic [PW-1:0]        p_rdata;
  logic [GRP_NUM_W-1:0] g_rdata;
  logic [DIMS_W-1:0]    dims_eff, dims_last;
  dist_ctl_t            dctl;
  logic                 dist_close;

  assign pr_data = p_rdata;

  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      unique case (d)
        0:       pw_data[d] = coord_x_i;
        1:       pw_data[d] = coord_y_i;
        default: pw_data[d] = coord_z_i;
      endcase
    end
  end

  always_comb begin
    if (dims_q == '0) begin
      dims_eff = DIMS_W'(1);
    end else if (dims_q > DimsMax) begin
      dims_eff = DimsMax;
    end else begin
      dims_eff = dims_q;
    end
    dims_last = dims_eff - DIMS_W'(1);
  end

  cpg_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_NODES)
  ) u_point_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (pts_q[IW-1:0]),
    .wdata_i (pw_data),
    .re_i    (p_re),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  cpg_ram #(
    .WIDTH (GRP_NUM_W),
    .DEPTH (MAX_NODES)
  ) u_group_ram (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (g_waddr),
    .wdata_i (grp_cnt_q[GRP_NUM_W-1:0]),
    .re_i    (g_re),
    .raddr_i (i_q[IW-1:0]),
    .rdata_o (g_rdata)
  );

  cpg_dist_unit u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (dctl),
    .a_i     (pi_q[k_q]),
    .b_i     (pr_data[k_q]),
    .tol_i   (tol_q),
    .close_o (dist_close)
  );

  always_comb begin
    state_d     = state_q;
    pts_d       = pts_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    grp_cnt_d   = grp_cnt_q;
    ovf_d       = ovf_q;
    cflt_d      = cflt_q;
    part_d      = part_q;
    grp_vld_d   = grp_vld_q;
    pi_d        = pr_data;
    pi_ld       = 1'b0;
    p_we        = 1'b0;
    p_re        = 1'b0;
    p_raddr     = i_q[IW-1:0];
    g_we        = 1'b0;
    g_re        = 1'b0;
    g_waddr     = i_q[IW-1:0];
    dctl        = '0;
    out_ld      = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_grp_d   = grp_vld_q[i_q[IW-1:0]] ? {1'b0, g_rdata} : '1;
    out_last_d  = (i_q == pts_q - NW'(1));
    if (cflt_q) begin
      out_stat_d = STATUS_CONFLICT;
    end else if (ovf_q) begin
      out_stat_d = STATUS_OVERFLOW;
    end else begin
      out_stat_d = STATUS_OK;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (pts_q == NodesMax) begin
            ovf_d = 1'b1;
          end else begin
            p_we  = 1'b1;
            pts_d = pts_q + NW'(1);
          end
          if (last_point_i) begin
            i_d     = '0;
            state_d = S_OUTER;
          end
        end
      end
      S_OUTER: begin
        if (i_q == pts_q) begin
          i_d     = '0;
          state_d = S_OUT_RD;
        end else if (grp_vld_q[i_q[IW-1:0]]) begin
          i_d = i_q + NW'(1);
        end else begin
          p_re    = 1'b1;
          state_d = S_LATCH_I;
        end
      end
      S_LATCH_I: begin
        pi_ld   = 1'b1;
        j_d     = i_q + NW'(1);
        part_d  = 1'b0;
        state_d = S_INNER;
      end
      S_INNER: begin
        if (j_q == pts_q) begin
          if (part_q) begin
            g_we                      = 1'b1;
            grp_vld_d[i_q[IW-1:0]]    = 1'b1;
            grp_cnt_d                 = grp_cnt_q + GRP_W'(1);
          end
          i_d     = i_q + NW'(1);
          state_d = S_OUTER;
        end else begin
          p_re     = 1'b1;
          p_raddr  = j_q[IW-1:0];
          dctl.clr = 1'b1;
          k_d      = '0;
          state_d  = S_MUL;
        end
      end
      S_MUL: begin
        dctl.mul = 1'b1;
        state_d  = S_ACC;
      end
      S_ACC: begin
        dctl.acc = 1'b1;
        if (k_q == dims_last[KW-1:0]) begin
          k_d     = '0;
          state_d = S_CMP;
        end else begin
          k_d     = k_q + KW'(1);
          state_d = S_MUL;
        end
      end
      S_CMP: begin
        if (dist_close) begin
          part_d = 1'b1;
          if (grp_vld_q[j_q[IW-1:0]]) begin
            cflt_d = 1'b1;
          end else begin
            g_we                   = 1'b1;
            g_waddr                = j_q[IW-1:0];
            grp_vld_d[j_q[IW-1:0]] = 1'b1;
          end
        end
        j_d     = j_q + NW'(1);
        state_d = S_INNER;
      end
      S_OUT_RD: begin
        if (!out_valid_q || out_ready_i) begin
          g_re    = 1'b1;
          state_d = S_OUT_LD;
        end
      end
      S_OUT_LD: begin
        out_ld      = 1'b1;
        out_valid_d = 1'b1;
        if (out_last_d) begin
          grp_vld_d = '0;
          pts_d     = '0;
          grp_cnt_d = '0;
          ovf_d     = 1'b0;
          cflt_d    = 1'b0;
          i_d       = '0;
          state_d   = S_IDLE;
        end else begin
          i_d     = i_q + NW'(1);
          state_d = S_OUT_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pts_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      grp_cnt_q   <= '0;
      ovf_q       <= 1'b0;
      cflt_q      <= 1'b0;
      part_q      <= 1'b0;
      grp_vld_q   <= '0;
      out_valid_q <= 1'b0;
      dims_q      <= DIMS_RESET;
      tol_q       <= '0;
    end else begin
      state_q     <= state_d;
      pts_q       <= pts_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      grp_cnt_q   <= grp_cnt_d;
      ovf_q       <= ovf_d;
      cflt_q      <= cflt_d;
      part_q      <= part_d;
      grp_vld_q   <= grp_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_DIMS: dims_q <= cfg_wdata_i[DIMS_W-1:0];
          REG_TOL:  tol_q  <= cfg_wdata_i[SUM_W-1:0];
          default:  dims_q <= dims_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pi_ld) begin
      pi_q <= pi_d;
    end
    if (out_ld) begin
      out_grp_q  <= out_grp_d;
      out_cnt_q  <= grp_cnt_q;
      out_stat_q <= out_stat_d;
      out_last_q <= out_last_d;
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign point_group_o  = out_grp_q;
  assign groups_found_o = out_cnt_q;
  assign status_o       = out_stat_q;
  assign last_result_o  = out_last_q;

  a_out_reg_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT_LD) |-> !out_valid_q)
    else $error("output register still occupied when loading a result");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pts_q <= NodesMax)
    else $error("point count beyond capacity");

  a_group_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_cnt_q <= GRP_W'(MAX_NODES / 2))
    else $error("more groups than point pairs");

  a_partner_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP && dist_close && !grp_vld_q[j_q[IW-1:0]])
    |=> grp_vld_q[$past(j_q[IW-1:0])])
    else $error("close partner not marked as grouped");

  a_idle_after_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT_LD && out_last_d) |=> (pts_q == '0 && grp_vld_q == '0))
    else $error("set not cleared after final result");

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for close_point_grouping_core: directed, capacity, stalls, random
`timescale 1ns / 1ps

module tb_top;
  import cpg_pkg::*;

  localparam int NODES        = DEF_MAX_NODES;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_REPORTS  = 10;

  localparam logic signed [COORD_W-1:0] C_MAX = 24'sh7FFFFF;
  localparam logic signed [COORD_W-1:0] C_MIN = 24'sh800000;

  typedef struct packed {
    logic signed [GRP_W-1:0] grp;
    logic [GRP_W-1:0]        found;
    logic [STATUS_W-1:0]     st;
    logic                    is_last;
  } grp_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic signed [COORD_W-1:0] coord_x = '0;
  logic signed [COORD_W-1:0] coord_y = '0;
  logic signed [COORD_W-1:0] coord_z = '0;
  logic                  last_point = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [GRP_W-1:0] point_group;
  logic [GRP_W-1:0]      groups_found;
  logic [STATUS_W-1:0]   status;
  logic                  last_result;

  // predictor state
  logic [DIMS_W-1:0]         dims_reg = DIMS_RESET;
  logic [CFG_DATA_W-1:0]     tol_reg = '0;
  logic signed [COORD_W-1:0] held_x [NODES];
  logic signed [COORD_W-1:0] held_y [NODES];
  logic signed [COORD_W-1:0] held_z [NODES];
  int                        point_grp [NODES];
  int                        held_count = 0;
  bit                        overflow_flag = 1'b0;
  grp_result_t               expected_groups_q [$];

  bit src_idle_en = 1'b1;
  bit sink_idle_en = 1'b1;
  int sink_hold_req = 0;

  int mismatch_count = 0;
  int results_checked = 0;
  int points_sent = 0;
  int sets_sent = 0;

  close_point_grouping_core u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .coord_x_i      (coord_x),
    .coord_y_i      (coord_y),
    .coord_z_i      (coord_z),
    .last_point_i   (last_point),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .point_group_o  (point_group),
    .groups_found_o (groups_found),
    .status_o       (status),
    .last_result_o  (last_result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("close_point_grouping_core: mismatch");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  function automatic bit pair_close(int a, int b);
    int nd;
    longint signed d;
    longint unsigned acc;
    nd = (dims_reg == 0) ? 1 : int'(dims_reg);
    acc = 0;
    d = longint'(held_x[a]) - longint'(held_x[b]);
    acc += d * d;
    if (nd > 1) begin
      d = longint'(held_y[a]) - longint'(held_y[b]);
      acc += d * d;
    end
    if (nd > 2) begin
      d = longint'(held_z[a]) - longint'(held_z[b]);
      acc += d * d;
    end
    return acc < 64'(tol_reg);
  endfunction

  // groups the held set and queues one result per held point
  function automatic void assign_groups();
    int i, j, n_groups;
    bit conflict, partnered;
    logic [STATUS_W-1:0] st;
    grp_result_t r;
    n_groups = 0;
    conflict = 1'b0;
    for (i = 0; i < held_count; i++) begin
      if (point_grp[i] == -1) begin
        partnered = 1'b0;
        for (j = i + 1; j < held_count; j++) begin
          if (pair_close(i, j)) begin
            partnered = 1'b1;
            if (point_grp[j] != -1) conflict = 1'b1;
            else point_grp[j] = n_groups;
          end
        end
        if (partnered) begin
          point_grp[i] = n_groups;
          n_groups++;
        end
      end
    end
    st = conflict ? STATUS_CONFLICT : (overflow_flag ? STATUS_OVERFLOW : STATUS_OK);
    for (i = 0; i < held_count; i++) begin
      r.grp = GRP_W'(point_grp[i]);
      r.found = GRP_W'(n_groups);
      r.st = st;
      r.is_last = (i == held_count - 1);
      expected_groups_q.push_back(r);
    end
    for (i = 0; i < NODES; i++) point_grp[i] = -1;
    held_count = 0;
    overflow_flag = 1'b0;
  endfunction

  function automatic void take_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                                     logic signed [COORD_W-1:0] z, logic is_last);
    if (held_count < NODES) begin
      held_x[held_count] = x;
      held_y[held_count] = y;
      held_z[held_count] = z;
      held_count++;
    end else begin
      overflow_flag = 1'b1;
    end
    if (is_last) begin
      assign_groups();
      sets_sent++;
    end
  endfunction

  function automatic void note_mismatch(string what, grp_result_t want, grp_result_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display({"%0t ERROR %s: exp grp %0d found %0d st %0d last %0d, ",
                "got grp %0d found %0d st %0d last %0d"},
               $realtime, what, want.grp, want.found, want.st, want.is_last,
               got.grp, got.found, got.st, got.is_last);
  endfunction

  // entered and left at a falling edge
  task automatic send_point(input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y,
                            input logic signed [COORD_W-1:0] z, input logic is_last);
    int gap;
    gap = src_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    coord_x <= x;
    coord_y <= y;
    coord_z <= z;
    last_point <= is_last;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    take_point(x, y, z, is_last);
    points_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_groups_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_DIMS) dims_reg = val[DIMS_W-1:0];
    else tol_reg = val;
  endtask

  task automatic send_random_set(input int n_pts, input int jit);
    logic [COORD_W-1:0] cx [4];
    logic [COORD_W-1:0] cy [4];
    logic [COORD_W-1:0] cz [4];
    logic [COORD_W-1:0] x, y, z;
    int k, c, n_cent;
    n_cent = $urandom_range(1, 4);
    for (c = 0; c < 4; c++) begin
      cx[c] = COORD_W'($urandom);
      cy[c] = COORD_W'($urandom);
      cz[c] = COORD_W'($urandom);
    end
    for (k = 0; k < n_pts; k++) begin
      if ($urandom_range(0, 4) == 0) begin
        x = COORD_W'($urandom);
        y = COORD_W'($urandom);
        z = COORD_W'($urandom);
      end else begin
        c = $urandom_range(0, n_cent - 1);
        x = cx[c] + COORD_W'($urandom_range(0, 2 * jit) - jit);
        y = cy[c] + COORD_W'($urandom_range(0, 2 * jit) - jit);
        z = cz[c] + COORD_W'($urandom_range(0, 2 * jit) - jit);
      end
      send_point(x, y, z, k == n_pts - 1);
    end
  endtask

  // single points and zero tolerance
  task automatic test_lone_points();
    wait_drain();
    write_reg(REG_DIMS, CFG_DATA_W'(3));
    write_reg(REG_TOL, '0);
    send_point(C_MAX, C_MAX, C_MAX, 1'b1);
    send_point(C_MIN, C_MIN, C_MIN, 1'b0);
    send_point(C_MIN, C_MIN, C_MIN, 1'b1);
  endtask

  // full-scale tolerance joins even opposite corners; dims 0 behaves as 1
  task automatic test_full_tolerance();
    wait_drain();
    write_reg(REG_TOL, '1);
    write_reg(REG_DIMS, CFG_DATA_W'(0));
    send_point(C_MIN, C_MIN, C_MIN, 1'b0);
    send_point(C_MAX, C_MAX, C_MAX, 1'b0);
    send_point('0, '0, '0, 1'b1);
    wait_drain();
    write_reg(REG_DIMS, CFG_DATA_W'(3));
    send_point(C_MIN, C_MAX, C_MIN, 1'b0);
    send_point(C_MAX, C_MIN, C_MAX, 1'b0);
    send_point(C_MIN, C_MIN, C_MAX, 1'b1);
  endtask

  task automatic test_dims_select();
    int d;
    for (d = 1; d <= 3; d++) begin
      wait_drain();
      write_reg(REG_TOL, CFG_DATA_W'(100));
      write_reg(REG_DIMS, CFG_DATA_W'(d));
      send_point(24'sd5, 24'sd5, 24'sd0, 1'b0);
      send_point(24'sd5, 24'sd5, 24'sd50, 1'b0);
      send_point(24'sd5, 24'sd70, 24'sd0, 1'b1);
    end
  endtask

  // distance equal to tolerance is not close; a shared partner gives a conflict
  task automatic test_conflict();
    wait_drain();
    write_reg(REG_TOL, CFG_DATA_W'(100));
    send_point(24'sd0, 24'sd0, 24'sd0, 1'b0);
    send_point(24'sd10, 24'sd0, 24'sd0, 1'b1);
    send_point(24'sd0, 24'sd0, 24'sd0, 1'b0);
    send_point(24'sd16, 24'sd0, 24'sd0, 1'b0);
    send_point(24'sd8, 24'sd0, 24'sd0, 1'b1);
  endtask

  task automatic test_capacity();
    wait_drain();
    write_reg(REG_DIMS, CFG_DATA_W'(1));
    write_reg(REG_TOL, CFG_DATA_W'(100));
    send_random_set(NODES, 4);
    send_random_set(NODES + 3, 4);
    send_point(-24'sd40, 24'sd1, 24'sd2, 1'b0);
    send_point(-24'sd24, 24'sd3, 24'sd4, 1'b0);
    send_point(-24'sd32, 24'sd5, 24'sd6, 1'b0);
    send_random_set(NODES - 2, 4);
  endtask

  // receiver stalls long while sets keep coming, then the sender waits for all results
  task automatic test_backpressure();
    int s, k;
    wait_drain();
    write_reg(REG_DIMS, CFG_DATA_W'(2));
    write_reg(REG_TOL, CFG_DATA_W'(2000));
    sink_hold_req = 400;
    for (s = 0; s < 4; s++)
      for (k = 0; k < 4; k++)
        send_point(COORD_W'(s * 1000 + k * 30), COORD_W'(-s), COORD_W'(k), k == 3);
    wait_drain();
    send_random_set(5, 20);
  endtask

  task automatic test_random_sets();
    int start, ph, s, n_sets, n_pts, jit, pick;
    logic [CFG_DATA_W-1:0] tol;
    start = points_sent;
    ph = 0;
    while (points_sent - start < 70) begin
      wait_drain();
      src_idle_en = (ph != 0);
      sink_idle_en = (ph != 0) && (ph != 2);
      jit = $urandom_range(0, 200);
      pick = $urandom_range(0, 9);
      if (pick == 0) tol = '0;
      else if (pick == 1) tol = '1;
      else if (pick == 2) tol = CFG_DATA_W'({$urandom, $urandom});
      else tol = CFG_DATA_W'($urandom_range(0, 12 * jit * jit + 1));
      write_reg(REG_DIMS, CFG_DATA_W'({$urandom, $urandom}));
      write_reg(REG_TOL, tol);
      n_sets = $urandom_range(3, 6);
      for (s = 0; s < n_sets; s++) begin
        if ($urandom_range(0, 19) == 0) n_pts = $urandom_range(16, 30);
        else n_pts = $urandom_range(1, 10);
        send_random_set(n_pts, jit);
      end
      ph++;
    end
  endtask

  // receiver ready with random gaps and requested long holds
  initial begin : sink_ready_proc
    int idle_left;
    int hold_left;
    idle_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (sink_hold_req > 0) begin
        hold_left = sink_hold_req;
        sink_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (sink_idle_en) idle_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : check_results
    grp_result_t got;
    grp_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {point_group, groups_found, status, last_result};
      if (expected_groups_q.size() == 0) begin
        note_mismatch("unexpected transaction", got, got);
      end else begin
        want = expected_groups_q.pop_front();
        results_checked++;
        if (got.grp !== want.grp || got.found !== want.found || got.st !== want.st ||
            got.is_last !== want.is_last)
          note_mismatch("result differs", want, got);
      end
    end
  end

  initial begin
    int i;
    for (i = 0; i < NODES; i++) point_grp[i] = -1;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_lone_points();
    test_full_tolerance();
    test_dims_select();
    test_conflict();
    test_capacity();
    test_backpressure();
    test_random_sets();
    wait_drain();
    $display("Covered %0d sets, %0d points, %0d results checked (%0d mismatches)",
             sets_sent, points_sent, results_checked, mismatch_count);
    $display("Dims 0..3, tolerance zero to full scale, conflicts, overflow and long stalls");
    if (mismatch_count == 0) begin
      $display("close_point_grouping_core: match");
    end else begin
      $display("close_point_grouping_core: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/cpg_pkg.sv
hw/rtl/cpg_ram.sv
hw/rtl/cpg_dist_unit.sv
hw/rtl/close_point_grouping_core.sv
tb/tb_top.sv
